// ===== hdl/jvr_pkg.sv =====
`timescale 1ns / 1ps

package jvr_pkg;

    // Register indexes of the configuration port
    localparam logic [2:0] CFG_ALPHA     = 3'd0;
    localparam logic [2:0] CFG_SNAP      = 3'd1;
    localparam logic [2:0] CFG_LIN_STEP  = 3'd2;
    localparam logic [2:0] CFG_ANG_STEP  = 3'd3;
    localparam logic [2:0] CFG_LIN_FLOOR = 3'd4;
    localparam logic [2:0] CFG_LIN_CEIL  = 3'd5;
    localparam logic [2:0] CFG_ANG_FLOOR = 3'd6;
    localparam logic [2:0] CFG_ANG_CEIL  = 3'd7;

    localparam int CFG_DATA_W = 17;

    // Unity filter weight in Q1.16
    localparam logic [16:0] ALPHA_ONE = 17'd65536;

    // Register reset values
    localparam logic [16:0]        RST_ALPHA = 17'd6554;
    localparam logic [14:0]        RST_SNAP  = 15'd41;
    localparam logic [14:0]        RST_STEP  = 15'd410;
    localparam logic signed [15:0] RST_FLOOR = 16'sd0;
    localparam logic signed [15:0] RST_CEIL  = 16'sd8192;

    // Buttons of one item, folded to the directions they mean
    typedef struct packed {
        logic start;
        logic left;
        logic right;
        logic fwd;
        logic back;
        logic slower;
        logic faster;
    } t_pad;

    // Settings of one target ramp
    typedef struct packed {
        logic [14:0]        step;
        logic signed [15:0] floor_val;
        logic signed [15:0] ceil_val;
    } t_ramp_cfg;

endpackage

// ===== hdl/jvr_axis_filter.sv =====
`timescale 1ns / 1ps

module jvr_axis_filter (
    input  logic signed [15:0] i_now,
    input  logic signed [15:0] i_target,
    input  logic               i_pos,
    input  logic               i_neg,
    input  logic [16:0]        i_alpha,
    input  logic [14:0]        i_snap,
    output logic signed [15:0] o_next
);
    import jvr_pkg::*;

    logic [16:0]        alpha_c;
    logic signed [16:0] goal;
    logic signed [17:0] diff;
    logic signed [35:0] prod;
    logic signed [36:0] sum;
    logic signed [20:0] res;
    logic signed [15:0] sat;
    logic [16:0]        mag;

    // now + alpha*(goal-now), which equals the weighted sum of goal and now
    always_comb begin
        alpha_c = (i_alpha > ALPHA_ONE) ? ALPHA_ONE : i_alpha;
        if (i_pos) begin
            goal = {i_target[15], i_target};
        end else if (i_neg) begin
            goal = -{i_target[15], i_target};
        end else begin
            goal = '0;
        end
        diff = {goal[16], goal} - {{2{i_now[15]}}, i_now};
        prod = $signed({1'b0, alpha_c}) * diff;
        sum  = {prod[35], prod} + {{5{i_now[15]}}, i_now, 16'b0};
        res  = sum[36:16];
        if (res > 21'sd32767) begin
            sat = 16'sh7fff;
        end else if (res < -21'sd32768) begin
            sat = 16'sh8000;
        end else begin
            sat = res[15:0];
        end
        mag = sat[15] ? -{sat[15], sat} : {sat[15], sat};
        o_next = (mag < {2'b00, i_snap}) ? 16'sd0 : sat;
    end

endmodule

// ===== hdl/jvr_target_ramp.sv =====
`timescale 1ns / 1ps

module jvr_target_ramp (
    input  logic signed [15:0]  i_target,
    input  logic                i_down,
    input  logic                i_up,
    input  jvr_pkg::t_ramp_cfg  i_cfg,
    output logic signed [15:0]  o_next
);
    import jvr_pkg::*;

    logic signed [17:0] step_ext;
    logic signed [17:0] sum;
    logic signed [17:0] lo;
    logic signed [17:0] hi;

    always_comb begin
        step_ext = {3'b000, i_cfg.step};
        lo  = {{2{i_cfg.floor_val[15]}}, i_cfg.floor_val};
        hi  = {{2{i_cfg.ceil_val[15]}}, i_cfg.ceil_val};
        sum = {{2{i_target[15]}}, i_target} + (i_down ? -step_ext : step_ext);
        // With no bumper the target is left alone, unclamped.
        if (!i_down && !i_up) begin
            o_next = i_target;
        end else if (sum < lo) begin
            o_next = i_cfg.floor_val;
        end else if (sum > hi) begin
            o_next = i_cfg.ceil_val;
        end else begin
            o_next = sum[15:0];
        end
    end

endmodule

// ===== hdl/joystick_velocity_ramp.sv =====
`timescale 1ns / 1ps
// An accepted item passes through the input register and then the result
// register, from which it is taken; a stall can hold it between the two.
// Throughput: one item per cycle; a full result register that is not taken
// stalls the input register, and through it the input channel.
// Reset (synchronous, active low) clears pause tracking, velocities and
// targets, empties both registers and loads the register defaults.

module joystick_velocity_ramp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Button snapshot channel
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_start_button,
    input  logic                            i_x_button,
    input  logic                            i_pad_left,
    input  logic                            i_b_button,
    input  logic                            i_pad_right,
    input  logic                            i_y_button,
    input  logic                            i_pad_up,
    input  logic                            i_a_button,
    input  logic                            i_pad_down,
    input  logic                            i_slower_button,
    input  logic                            i_faster_button,
    // Velocity result channel
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic signed [15:0]              o_linear_out,
    output logic signed [15:0]              o_angular_out,
    // Configuration writes
    input  logic                            i_cfg_wr_en,
    input  logic [2:0]                      i_cfg_index,
    input  logic [jvr_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import jvr_pkg::*;

    // Configuration registers. The user must change them only while the block is
    // idle, which the block does not enforce; the datapath reads them directly.
    logic [16:0] r_alpha;
    logic [14:0] r_snap;
    t_ramp_cfg   r_lin_cfg;
    t_ramp_cfg   r_ang_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha             <= RST_ALPHA;
            r_snap              <= RST_SNAP;
            r_lin_cfg.step      <= RST_STEP;
            r_ang_cfg.step      <= RST_STEP;
            r_lin_cfg.floor_val <= RST_FLOOR;
            r_lin_cfg.ceil_val  <= RST_CEIL;
            r_ang_cfg.floor_val <= RST_FLOOR;
            r_ang_cfg.ceil_val  <= RST_CEIL;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_ALPHA:     r_alpha             <= i_cfg_data;
                CFG_SNAP:      r_snap              <= i_cfg_data[14:0];
                CFG_LIN_STEP:  r_lin_cfg.step      <= i_cfg_data[14:0];
                CFG_ANG_STEP:  r_ang_cfg.step      <= i_cfg_data[14:0];
                CFG_LIN_FLOOR: r_lin_cfg.floor_val <= i_cfg_data[15:0];
                CFG_LIN_CEIL:  r_lin_cfg.ceil_val  <= i_cfg_data[15:0];
                CFG_ANG_FLOOR: r_ang_cfg.floor_val <= i_cfg_data[15:0];
                CFG_ANG_CEIL:  r_ang_cfg.ceil_val  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Input register. The buttons are folded into directions as they are
    // captured, so the stage behind it sees only what matters.
    logic r_in_valid;
    t_pad r_pad;
    logic advance;
    logic stall;

    // The input register holds its item only while a result is waiting in
    // the result register and is not being taken in this cycle.
    assign stall   = r_in_valid && o_valid && !i_ready;
    assign advance = r_in_valid && !stall;
    assign o_ready = !r_in_valid || !stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_pad.start  <= i_start_button;
            r_pad.left   <= i_x_button | i_pad_left;
            r_pad.right  <= i_b_button | i_pad_right;
            r_pad.fwd    <= i_y_button | i_pad_up;
            r_pad.back   <= i_a_button | i_pad_down;
            r_pad.slower <= i_slower_button;
            r_pad.faster <= i_faster_button;
        end
    end

    // Start button tracking. The first item after reset only records the
    // level of start. After that a press arms the toggle and the following
    // released item flips pause; while paused no result is produced.
    logic r_seen_first;
    logic r_last_start;
    logic r_armed;
    logic r_paused;
    logic n_armed;
    logic n_paused;
    logic emit;

    always_comb begin
        n_armed  = r_armed;
        n_paused = r_paused;
        if (r_pad.start && !r_last_start) begin
            n_armed = 1'b1;
        end else if (!r_pad.start && r_armed) begin
            n_armed  = 1'b0;
            n_paused = !r_paused;
        end
        emit = r_seen_first && !n_paused;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_first <= 1'b0;
            r_last_start <= 1'b0;
            r_armed      <= 1'b0;
            r_paused     <= 1'b0;
        end else if (advance) begin
            r_seen_first <= 1'b1;
            r_last_start <= r_pad.start;
            if (r_seen_first) begin
                r_armed  <= n_armed;
                r_paused <= n_paused;
            end
        end
    end

    // Smoothing of both axes and the target ramps, all combinational. Left
    // and forward win over their opposite direction; the slower bumper wins
    // over the faster one. The filters use the targets from before the ramp.
    logic signed [15:0] r_lin_now;
    logic signed [15:0] r_ang_now;
    logic signed [15:0] r_lin_target;
    logic signed [15:0] r_ang_target;
    logic signed [15:0] n_lin_now;
    logic signed [15:0] n_ang_now;
    logic signed [15:0] n_lin_target;
    logic signed [15:0] n_ang_target;

    jvr_axis_filter u_lin_filter (
        .i_now    (r_lin_now),
        .i_target (r_lin_target),
        .i_pos    (r_pad.fwd),
        .i_neg    (r_pad.back),
        .i_alpha  (r_alpha),
        .i_snap   (r_snap),
        .o_next   (n_lin_now)
    );

    jvr_axis_filter u_ang_filter (
        .i_now    (r_ang_now),
        .i_target (r_ang_target),
        .i_pos    (r_pad.left),
        .i_neg    (r_pad.right),
        .i_alpha  (r_alpha),
        .i_snap   (r_snap),
        .o_next   (n_ang_now)
    );

    jvr_target_ramp u_lin_ramp (
        .i_target (r_lin_target),
        .i_down   (r_pad.slower),
        .i_up     (r_pad.faster),
        .i_cfg    (r_lin_cfg),
        .o_next   (n_lin_target)
    );

    jvr_target_ramp u_ang_ramp (
        .i_target (r_ang_target),
        .i_down   (r_pad.slower),
        .i_up     (r_pad.faster),
        .i_cfg    (r_ang_cfg),
        .o_next   (n_ang_target)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lin_now    <= '0;
            r_ang_now    <= '0;
            r_lin_target <= '0;
            r_ang_target <= '0;
        end else if (advance && emit) begin
            r_lin_now    <= n_lin_now;
            r_ang_now    <= n_ang_now;
            r_lin_target <= n_lin_target;
            r_ang_target <= n_ang_target;
        end
    end

    // Result register. It refills in the same cycle that its item is taken.
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            o_linear_out  <= n_lin_now;
            o_angular_out <= n_ang_now;
        end
    end

    assign o_valid = r_out_valid;

endmodule

// ===== sim/joystick_velocity_ramp_checker.sv =====
`timescale 1ns / 1ps

module joystick_velocity_ramp_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic                            i_start_button,
    input  logic                            i_x_button,
    input  logic                            i_pad_left,
    input  logic                            i_b_button,
    input  logic                            i_pad_right,
    input  logic                            i_y_button,
    input  logic                            i_pad_up,
    input  logic                            i_a_button,
    input  logic                            i_pad_down,
    input  logic                            i_slower_button,
    input  logic                            i_faster_button,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic signed [15:0]              i_linear_out,
    input  logic signed [15:0]              i_angular_out,
    input  logic                            i_cfg_wr_en,
    input  logic [2:0]                      i_cfg_index,
    input  logic [jvr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);
    import jvr_pkg::*;

    typedef struct packed {
        logic signed [15:0] linear;
        logic signed [15:0] angular;
    } velocity_t;

    // Shadow copy of the settings.
    logic [16:0]        alpha;
    logic [14:0]        snap;
    logic [14:0]        lin_step;
    logic [14:0]        ang_step;
    logic signed [15:0] lin_floor;
    logic signed [15:0] lin_ceil;
    logic signed [15:0] ang_floor;
    logic signed [15:0] ang_ceil;

    // Shadow copy of the pause tracking, velocities and targets.
    logic               seen_first;
    logic               last_start;
    logic               press_armed;
    logic               paused;
    logic signed [15:0] lin_now;
    logic signed [15:0] ang_now;
    logic signed [15:0] lin_tgt;
    logic signed [15:0] ang_tgt;

    velocity_t due_velocity[$];
    int        fail_count = 0;
    int        due_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = due_count;

    // One smoothing step towards the goal, floored, saturated, then snapped.
    function automatic logic signed [15:0] smooth_axis(logic signed [15:0] now, int goal);
        longint weight;
        longint acc;
        longint r;
        longint mag;
        if (alpha > ALPHA_ONE)
            weight = 65536;
        else
            weight = longint'(alpha);
        acc = weight * longint'(goal) + (65536 - weight) * longint'(now);
        r = acc >>> 16;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        mag = (r < 0) ? -r : r;
        if (mag < longint'(snap))
            r = 0;
        return r[15:0];
    endfunction

    // The floor is tested first, so a floor above the ceiling still wins below it.
    function automatic logic signed [15:0] ramp_target(logic signed [15:0] tgt, int delta,
                                                       logic signed [15:0] lo,
                                                       logic signed [15:0] hi);
        int v;
        v = int'(tgt) + delta;
        if (v < int'(lo))
            v = int'(lo);
        else if (v > int'(hi))
            v = int'(hi);
        return v[15:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        fail_count++;
    endtask

    task automatic predict_velocity();
        logic      left;
        logic      right;
        logic      fwd;
        logic      back;
        int        goal;
        velocity_t v;
        left  = i_x_button | i_pad_left;
        right = i_b_button | i_pad_right;
        fwd   = i_y_button | i_pad_up;
        back  = i_a_button | i_pad_down;
        if (!seen_first) begin
            last_start = i_start_button;
            seen_first = 1'b1;
            return;
        end
        if (i_start_button && !last_start) begin
            press_armed = 1'b1;
        end else if (!i_start_button && press_armed) begin
            press_armed = 1'b0;
            paused = !paused;
        end
        last_start = i_start_button;
        if (paused)
            return;
        goal = left ? int'(ang_tgt) : (right ? -int'(ang_tgt) : 0);
        ang_now = smooth_axis(ang_now, goal);
        goal = fwd ? int'(lin_tgt) : (back ? -int'(lin_tgt) : 0);
        lin_now = smooth_axis(lin_now, goal);
        v.linear  = lin_now;
        v.angular = ang_now;
        due_velocity.push_back(v);
        if (i_slower_button) begin
            lin_tgt = ramp_target(lin_tgt, -int'(lin_step), lin_floor, lin_ceil);
            ang_tgt = ramp_target(ang_tgt, -int'(ang_step), ang_floor, ang_ceil);
        end else if (i_faster_button) begin
            lin_tgt = ramp_target(lin_tgt, int'(lin_step), lin_floor, lin_ceil);
            ang_tgt = ramp_target(ang_tgt, int'(ang_step), ang_floor, ang_ceil);
        end
    endtask

    always @(posedge i_clk) begin
        velocity_t want;
        if (!i_rst_n) begin
            alpha       = RST_ALPHA;
            snap        = RST_SNAP;
            lin_step    = RST_STEP;
            ang_step    = RST_STEP;
            lin_floor   = RST_FLOOR;
            lin_ceil    = RST_CEIL;
            ang_floor   = RST_FLOOR;
            ang_ceil    = RST_CEIL;
            seen_first  = 1'b0;
            last_start  = 1'b0;
            press_armed = 1'b0;
            paused      = 1'b0;
            lin_now     = '0;
            ang_now     = '0;
            lin_tgt     = '0;
            ang_tgt     = '0;
            due_velocity.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_ALPHA:     alpha     = i_cfg_data[16:0];
                    CFG_SNAP:      snap      = i_cfg_data[14:0];
                    CFG_LIN_STEP:  lin_step  = i_cfg_data[14:0];
                    CFG_ANG_STEP:  ang_step  = i_cfg_data[14:0];
                    CFG_LIN_FLOOR: lin_floor = i_cfg_data[15:0];
                    CFG_LIN_CEIL:  lin_ceil  = i_cfg_data[15:0];
                    CFG_ANG_FLOOR: ang_floor = i_cfg_data[15:0];
                    CFG_ANG_CEIL:  ang_ceil  = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (due_velocity.size() == 0) begin
                    report_mismatch($sformatf("velocity item %0d/%0d with none due",
                                              i_linear_out, i_angular_out));
                end else begin
                    want = due_velocity.pop_front();
                    if (i_linear_out !== want.linear)
                        report_mismatch($sformatf("linear expected %0d, got %0d",
                                                  want.linear, i_linear_out));
                    if (i_angular_out !== want.angular)
                        report_mismatch($sformatf("angular expected %0d, got %0d",
                                                  want.angular, i_angular_out));
                end
            end
            if (i_in_valid && i_in_ready)
                predict_velocity();
        end
        due_count = due_velocity.size();
    end

endmodule

// ===== sim/joystick_velocity_ramp_tb.sv =====
`timescale 1ns / 1ps

module joystick_velocity_ramp_tb;
    import jvr_pkg::*;

    // One button snapshot, start in the least significant bit.
    typedef struct packed {
        logic faster;
        logic slower;
        logic pad_down;
        logic a;
        logic pad_up;
        logic y;
        logic pad_right;
        logic b;
        logic pad_left;
        logic x;
        logic start;
    } buttons_t;

    // Masks for composing directed snapshots, matching the field order above.
    localparam logic [10:0] P_NONE  = 11'h000;
    localparam logic [10:0] P_START = 11'h001;
    localparam logic [10:0] P_X     = 11'h002;
    localparam logic [10:0] P_PAD_L = 11'h004;
    localparam logic [10:0] P_B     = 11'h008;
    localparam logic [10:0] P_PAD_R = 11'h010;
    localparam logic [10:0] P_Y     = 11'h020;
    localparam logic [10:0] P_PAD_U = 11'h040;
    localparam logic [10:0] P_A     = 11'h080;
    localparam logic [10:0] P_PAD_D = 11'h100;
    localparam logic [10:0] P_LB    = 11'h200;
    localparam logic [10:0] P_RB    = 11'h400;
    localparam logic [10:0] P_ALL   = 11'h7FF;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   pad_valid = 1'b0;
    logic                   pad_ready;
    buttons_t               pad = '0;
    logic                   vel_valid;
    logic                   vel_ready = 1'b0;
    logic signed [15:0]     linear_out;
    logic signed [15:0]     angular_out;
    logic                   cfg_wr_en = 1'b0;
    logic [2:0]             cfg_index = CFG_ALPHA;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    int                     fail_count;
    int                     pending;
    // When set, neither side inserts any gaps, so items run back to back.
    bit                     quiet = 1'b0;
    int                     phase_items;

    always #4 clk = ~clk;

    joystick_velocity_ramp dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_valid         (pad_valid),
        .o_ready         (pad_ready),
        .i_start_button  (pad.start),
        .i_x_button      (pad.x),
        .i_pad_left      (pad.pad_left),
        .i_b_button      (pad.b),
        .i_pad_right     (pad.pad_right),
        .i_y_button      (pad.y),
        .i_pad_up        (pad.pad_up),
        .i_a_button      (pad.a),
        .i_pad_down      (pad.pad_down),
        .i_slower_button (pad.slower),
        .i_faster_button (pad.faster),
        .o_valid         (vel_valid),
        .i_ready         (vel_ready),
        .o_linear_out    (linear_out),
        .o_angular_out   (angular_out),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    // The checker watches both channels and the register writes on its own.
    joystick_velocity_ramp_checker velocity_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (pad_valid),
        .i_in_ready      (pad_ready),
        .i_start_button  (pad.start),
        .i_x_button      (pad.x),
        .i_pad_left      (pad.pad_left),
        .i_b_button      (pad.b),
        .i_pad_right     (pad.pad_right),
        .i_y_button      (pad.y),
        .i_pad_up        (pad.pad_up),
        .i_a_button      (pad.a),
        .i_pad_down      (pad.pad_down),
        .i_slower_button (pad.slower),
        .i_faster_button (pad.faster),
        .i_out_valid     (vel_valid),
        .i_out_ready     (vel_ready),
        .i_linear_out    (linear_out),
        .i_angular_out   (angular_out),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // Gap length shared by both sides: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // A register value that lands on either end of its range fairly often.
    function automatic int pick_value(int lo, int hi, int typ_lo, int typ_hi);
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return lo;
        if (r < 30)
            return hi;
        return typ_lo + int'($urandom_range(0, typ_hi - typ_lo));
    endfunction

    // Mostly plausible play: start is rarely touched, so that pause toggles now
    // and then rather than constantly, and the bumpers move the targets about.
    // One snapshot in ten is pure noise.
    function automatic buttons_t random_buttons();
        buttons_t b;
        if ($urandom_range(0, 9) == 0)
            return buttons_t'(11'($urandom()));
        b.start     = ($urandom_range(0, 99) < 6);
        b.x         = ($urandom_range(0, 99) < 30);
        b.pad_left  = ($urandom_range(0, 99) < 30);
        b.b         = ($urandom_range(0, 99) < 30);
        b.pad_right = ($urandom_range(0, 99) < 30);
        b.y         = ($urandom_range(0, 99) < 30);
        b.pad_up    = ($urandom_range(0, 99) < 30);
        b.a         = ($urandom_range(0, 99) < 30);
        b.pad_down  = ($urandom_range(0, 99) < 30);
        b.slower    = ($urandom_range(0, 99) < 15);
        b.faster    = ($urandom_range(0, 99) < 25);
        return b;
    endfunction

    // Presents one snapshot and returns on the edge that accepts it. Valid is
    // left high, so a following item with no gap goes straight through. The
    // ready is looked at on the falling edge, where it is settled.
    task automatic send_buttons(input buttons_t b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            pad_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pad       <= b;
        pad_valid <= 1'b1;
        do @(negedge clk); while (!pad_ready);
        @(posedge clk);
    endtask

    // Stops the input side and waits until every velocity item due has come
    // out. Snapshots that give no result may still be in the pipeline, so it
    // goes on waiting after that for them to pass through.
    task automatic drain_results();
        pad_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (6) @(posedge clk);
    endtask

    // Write enable is left high between back-to-back writes and is lowered by
    // the caller once the last one is through.
    task automatic drive_reg(input logic [2:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // Writes all eight registers. The bits above each register's width are
    // filled at random, since the block must ignore them.
    task automatic apply_settings(input int alpha, input int snap,
                                  input int lin_step, input int ang_step,
                                  input int lin_floor, input int lin_ceil,
                                  input int ang_floor, input int ang_ceil);
        drive_reg(CFG_ALPHA,     17'(alpha));
        drive_reg(CFG_SNAP,      {2'($urandom_range(0, 3)), 15'(snap)});
        drive_reg(CFG_LIN_STEP,  {2'($urandom_range(0, 3)), 15'(lin_step)});
        drive_reg(CFG_ANG_STEP,  {2'($urandom_range(0, 3)), 15'(ang_step)});
        drive_reg(CFG_LIN_FLOOR, {1'($urandom_range(0, 1)), 16'(lin_floor)});
        drive_reg(CFG_LIN_CEIL,  {1'($urandom_range(0, 1)), 16'(lin_ceil)});
        drive_reg(CFG_ANG_FLOOR, {1'($urandom_range(0, 1)), 16'(ang_floor)});
        drive_reg(CFG_ANG_CEIL,  {1'($urandom_range(0, 1)), 16'(ang_ceil)});
        cfg_wr_en <= 1'b0;
    endtask

    task automatic randomise_settings();
        int alpha;
        case ($urandom_range(0, 5))
            0:       alpha = 0;
            1:       alpha = 65536;
            2:       alpha = 65537 + int'($urandom_range(0, 65534));
            default: alpha = $urandom_range(300, 40000);
        endcase
        apply_settings(alpha,
                       pick_value(0, 32767, 0, 300),
                       pick_value(0, 32767, 0, 3000),
                       pick_value(0, 32767, 0, 3000),
                       pick_value(-32768, 32767, -12000, 12000),
                       pick_value(-32768, 32767, -12000, 12000),
                       pick_value(-32768, 32767, -12000, 12000),
                       pick_value(-32768, 32767, -12000, 12000));
    endtask

    // The result side: bursts of ready broken by stalls of the same mix of
    // lengths as the input gaps.
    initial begin
        int run;
        int stall;
        @(posedge clk);
        forever begin
            run = $urandom_range(1, 24);
            vel_ready <= 1'b1;
            repeat (run) @(posedge clk);
            stall = pick_gap();
            if (stall > 0) begin
                vel_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings. The first snapshot only records start, so pressing
        // everything must give nothing; releasing start afterwards must not
        // pause, as start was never seen going down.
        send_buttons(buttons_t'(P_ALL));
        send_buttons(buttons_t'(P_NONE));
        send_buttons(buttons_t'(P_RB));
        send_buttons(buttons_t'(P_Y | P_X | P_RB));
        send_buttons(buttons_t'(P_PAD_U | P_PAD_L | P_RB));
        // Opposite directions together: forward and left take precedence.
        send_buttons(buttons_t'(P_Y | P_A | P_X | P_B));
        // Both bumpers: the slower one takes precedence.
        send_buttons(buttons_t'(P_PAD_D | P_PAD_R | P_LB | P_RB));
        send_buttons(buttons_t'(P_A | P_B));
        // Press start, hold it, release it: the release pauses the block,
        // after which a bumper must neither give a result nor move a target.
        send_buttons(buttons_t'(P_START | P_PAD_U));
        send_buttons(buttons_t'(P_START | P_PAD_U));
        send_buttons(buttons_t'(P_NONE));
        send_buttons(buttons_t'(P_RB | P_Y));
        // A second press and release resumes, and the resuming item itself
        // already gives a result.
        send_buttons(buttons_t'(P_START));
        send_buttons(buttons_t'(P_PAD_D));
        send_buttons(buttons_t'(P_LB));

        // Unity weight, no snapping, widest steps and a linear target pinned to
        // the most negative value. Backwards then aims at plus 32768, which
        // has to saturate.
        drain_results();
        apply_settings(65536, 0, 32767, 32767, -32768, -32768, -32768, 32767);
        send_buttons(buttons_t'(P_LB));
        send_buttons(buttons_t'(P_A | P_X));
        send_buttons(buttons_t'(P_PAD_D | P_PAD_R));

        // A weight above one acts as one; floors above ceilings put the
        // target on the floor going up from below, and on the ceiling once
        // it has passed the floor.
        drain_results();
        apply_settings(131071, 41, 5, 5, 100, -100, 0, 0);
        send_buttons(buttons_t'(P_RB | P_Y));
        send_buttons(buttons_t'(P_RB | P_PAD_U));
        send_buttons(buttons_t'(P_Y));
        send_buttons(buttons_t'(P_X | P_PAD_R));

        // Random play in phases, each under its own settings. The first goes
        // back to the reset values, and every third runs without any gaps.
        for (int phase = 0; phase < 8; phase++) begin
            drain_results();
            if (phase == 0)
                apply_settings(RST_ALPHA, RST_SNAP, RST_STEP, RST_STEP,
                               RST_FLOOR, RST_CEIL, RST_FLOOR, RST_CEIL);
            else
                randomise_settings();
            quiet = (phase % 3 == 2);
            phase_items = $urandom_range(80, 120);
            repeat (phase_items) send_buttons(random_buttons());
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("joystick_velocity_ramp_tb OK");
        else
            $display("joystick_velocity_ramp_tb NOT OK");
        $finish;
    end

    // Guard against a hang: a correct run takes well under a fifth of this.
    initial begin
        #5_000_000;
        $display("joystick_velocity_ramp_tb NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/jvr_pkg.sv
hdl/jvr_axis_filter.sv
hdl/jvr_target_ramp.sv
hdl/joystick_velocity_ramp.sv
sim/joystick_velocity_ramp_checker.sv
sim/joystick_velocity_ramp_tb.sv
